[hw/rtl/kau_pkg.sv]
package kau_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 8;
    localparam int MAX_POINTS   = 65536;

    localparam int CL_W   = $clog2(MAX_CLUSTERS);
    localparam int DIM_W  = $clog2(MAX_DIMS);
    localparam int NC_W   = CL_W + 1;
    localparam int ND_W   = DIM_W + 1;
    localparam int CNT_W  = 17;
    localparam int DIST_W = 40;
    localparam int SUM_W  = 32;
    localparam int VAL_W  = 16;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 5;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_ASSIGN = 2'd0;
    localparam logic [1:0] KIND_MEAN   = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    localparam logic [CFG_IW-1:0] REG_CLUSTERS = 2'd0;
    localparam logic [CFG_IW-1:0] REG_DIMS     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_SKIP     = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic [3:0]              cluster_sel;
        logic [2:0]              elem_index;
        logic signed [VAL_W-1:0] elem_value;
        logic [15:0]             point_id;
    } req_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [15:0]             assigned_point;
        logic                    found;
        logic [3:0]              cluster_out;
        logic [CNT_W-1:0]        member_count;
        logic [2:0]              mean_index;
        logic signed [VAL_W-1:0] mean_value;
        logic                    last;
    } res_t;

    typedef struct packed {
        logic                    en;
        logic [CL_W-1:0]         sel;
        logic [DIM_W-1:0]        elem;
        logic signed [VAL_W-1:0] value;
    } cload_t;

    typedef struct packed {
        logic                    start;
        logic [DIM_W-1:0]        elem;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } dist_req_t;

    typedef struct packed {
        logic            done;
        logic            found;
        logic [CL_W-1:0] best;
    } dist_res_t;

    typedef struct packed {
        logic              eq;
        logic [DIST_W-1:0] acc;
    } pent_t;

    function automatic logic [NC_W-1:0] eff_clusters(input logic [CFG_DW-1:0] v);
        logic [NC_W-1:0] r;
        if (v == '0)
            r = NC_W'(1);
        else if (v > CFG_DW'(MAX_CLUSTERS))
            r = NC_W'(MAX_CLUSTERS);
        else
            r = NC_W'(v);
        return r;
    endfunction

    function automatic logic [ND_W-1:0] eff_dims(input logic [3:0] v);
        logic [ND_W-1:0] r;
        if (v == '0)
            r = ND_W'(1);
        else if (v > 4'(MAX_DIMS))
            r = ND_W'(MAX_DIMS);
        else
            r = ND_W'(v);
        return r;
    endfunction

endpackage

[hw/rtl/kmeans_assign_update_core.sv]
// Channel  | Signals                         | Moves
// in       | in_valid, in_ready, in_data     | one request (req_t) per handshake
// out      | out_valid, out_ready, out_data  | one result (res_t) per handshake
// cfg      | cfg_valid, cfg_ready, cfg_index | register write, cfg_data as value
//
// Work per request: a load or clear request is handled in the idle state; a
// point element steps one centroid per cycle through the centroid and
// partial-distance memories. A point's last element then reads the count and
// does the 8-entry read-modify-write of the cluster sums. A drain skips clusters
// that hold no members and computes each mean element with the 32-step divider.
// Reset needs no clearing pass. A stalled output register holds its result while
// the next one waits; input is taken again once the request is fully processed.
module kmeans_assign_update_core
    import kau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  req_t              in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIST   = 4'd1;
    localparam logic [3:0] S_CNT    = 4'd2;
    localparam logic [3:0] S_UPD_RD = 4'd3;
    localparam logic [3:0] S_UPD_WR = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_DSCAN  = 4'd6;
    localparam logic [3:0] S_DCNT   = 4'd7;
    localparam logic [3:0] S_DRD    = 4'd8;
    localparam logic [3:0] S_DDIV   = 4'd9;
    localparam logic [3:0] S_DWAIT  = 4'd10;

    localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(MAX_DIMS - 1);

    logic [3:0]        state_reg, state_next;
    logic [CFG_DW-1:0] act_cl_reg;
    logic [3:0]        act_dim_reg;
    logic              skip_reg;
    logic [NC_W-1:0]   nc;
    logic [ND_W-1:0]   nd;

    logic signed [VAL_W-1:0] pb_reg [MAX_DIMS];
    logic [NC_W-1:0]   c_reg, c_next;
    logic [DIM_W-1:0]  d_reg, d_next;
    logic [NC_W-1:0]   dp_reg, dp_next;
    logic [15:0]       pid_reg, pid_next;
    logic              lastpt_reg, lastpt_next;
    logic [CNT_W-1:0]  newcnt_reg, newcnt_next;
    logic [CNT_W-1:0]  dcnt_reg, dcnt_next;
    res_t              emit_reg, emit_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_data_reg, out_data_next;
    logic [MAX_CLUSTERS-1:0] cvalid_reg, cvalid_next;

    logic signed [SUM_W-1:0] sum_mem [MAX_CLUSTERS*MAX_DIMS];
    logic [CNT_W-1:0]        cnt_mem [MAX_CLUSTERS];
    logic signed [SUM_W-1:0] sum_q;
    logic [CNT_W-1:0]        cnt_q;
    logic                    cnt_qv;
    logic [CL_W+DIM_W-1:0]   sum_addr;
    logic [CL_W-1:0]         cnt_raddr;
    logic                    sum_we, cnt_we;
    logic signed [SUM_W-1:0] sum_wdata;
    logic [CNT_W-1:0]        cnt_cur;

    logic      in_acc;
    cload_t    cload;
    dist_req_t dreq;
    dist_res_t dres;
    logic      div_start, div_done;
    logic signed [VAL_W-1:0] div_q;

    assign nc        = eff_clusters(act_cl_reg);
    assign nd        = eff_dims(act_dim_reg);
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cload.en    = in_acc && (in_data.op == OP_LOAD);
    assign cload.sel   = in_data.cluster_sel;
    assign cload.elem  = in_data.elem_index;
    assign cload.value = in_data.elem_value;

    assign dreq.start = in_acc && (in_data.op == OP_POINT)
                        && ({1'b0, in_data.elem_index} < nd);
    assign dreq.elem  = in_data.elem_index;
    assign dreq.value = in_data.elem_value;
    assign dreq.last  = ({1'b0, in_data.elem_index} == nd - ND_W'(1));

    kau_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .cload      (cload),
        .req        (dreq),
        .nclusters  (nc),
        .skip_equal (skip_reg),
        .res        (dres)
    );

    assign div_start = (state_reg == S_DDIV);

    kau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_q),
        .divisor  (dcnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sum_addr  = {c_reg[CL_W-1:0], d_reg};
    assign cnt_raddr = (state_reg == S_DIST) ? dres.best : c_reg[CL_W-1:0];
    assign cnt_cur   = cnt_qv ? cnt_q : '0;
    assign sum_we    = (state_reg == S_UPD_WR);
    assign sum_wdata = (cvalid_reg[c_reg[CL_W-1:0]] ? sum_q : SUM_W'(0))
                       + (({1'b0, d_reg} < nd) ? SUM_W'(pb_reg[d_reg]) : SUM_W'(0));
    assign cnt_we    = (state_reg == S_UPD_WR) && (d_reg == DIM_LAST);

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_addr] <= sum_wdata;
        sum_q <= sum_mem[sum_addr];
        if (cnt_we)
            cnt_mem[c_reg[CL_W-1:0]] <= newcnt_reg;
        cnt_q  <= cnt_mem[cnt_raddr];
        cnt_qv <= cvalid_reg[cnt_raddr];
        if (dreq.start)
            pb_reg[in_data.elem_index] <= in_data.elem_value;
    end

    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        dp_next        = dp_reg;
        pid_next       = pid_reg;
        lastpt_next    = lastpt_reg;
        newcnt_next    = newcnt_reg;
        dcnt_next      = dcnt_reg;
        emit_next      = emit_reg;
        cvalid_next    = cvalid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_data.op)
                        OP_LOAD:
                        begin
                        end
                        OP_POINT:
                        begin
                            if (dreq.start)
                            begin
                                pid_next    = in_data.point_id;
                                lastpt_next = dreq.last;
                                state_next  = S_DIST;
                            end
                        end
                        OP_DRAIN:
                        begin
                            c_next     = dp_reg;
                            state_next = S_DSCAN;
                        end
                        OP_CLEAR:
                        begin
                            cvalid_next = '0;
                            dp_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIST:
            begin
                if (dres.done)
                begin
                    emit_next = '0;
                    emit_next.kind = KIND_ASSIGN;
                    emit_next.assigned_point = pid_reg;
                    c_next = NC_W'(dres.best);
                    if (!lastpt_reg)
                        state_next = S_IDLE;
                    else if (!dres.found)
                        state_next = S_EMIT;
                    else
                        state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                emit_next.found       = 1'b1;
                emit_next.cluster_out = c_reg[CL_W-1:0];
                if (cnt_cur < CNT_W'(MAX_POINTS))
                begin
                    newcnt_next = cnt_cur + CNT_W'(1);
                    d_next      = '0;
                    state_next  = S_UPD_RD;
                end
                else
                begin
                    // saturated cluster: report but leave sums alone
                    emit_next.member_count = cnt_cur;
                    state_next = S_EMIT;
                end
            end
            S_UPD_RD:
            begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                if (d_reg == DIM_LAST)
                begin
                    cvalid_next[c_reg[CL_W-1:0]] = 1'b1;
                    emit_next.member_count = newcnt_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    d_next     = d_reg + DIM_W'(1);
                    state_next = S_UPD_RD;
                end
            end
            S_DSCAN:
            begin
                if (c_reg >= nc)
                begin
                    emit_next      = '0;
                    emit_next.kind = KIND_DONE;
                    dp_next        = '0;
                    state_next     = S_EMIT;
                end
                else if (cvalid_reg[c_reg[CL_W-1:0]])
                    state_next = S_DCNT;
                else
                    c_next = c_reg + NC_W'(1);
            end
            S_DCNT:
            begin
                dcnt_next  = cnt_q;
                d_next     = '0;
                state_next = S_DRD;
            end
            S_DRD:
            begin
                state_next = S_DDIV;
            end
            S_DDIV:
            begin
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    emit_next              = '0;
                    emit_next.kind         = KIND_MEAN;
                    emit_next.cluster_out  = c_reg[CL_W-1:0];
                    emit_next.member_count = dcnt_reg;
                    emit_next.mean_index   = d_reg;
                    emit_next.mean_value   = div_q;
                    emit_next.last         = ({1'b0, d_reg} == nd - ND_W'(1));
                    if (emit_next.last)
                        dp_next = c_reg + NC_W'(1);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = emit_reg;
                    if (emit_reg.kind == KIND_MEAN && !emit_reg.last)
                    begin
                        d_next     = d_reg + DIM_W'(1);
                        state_next = S_DRD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_cl_reg    <= CFG_DW'(16);
            act_dim_reg   <= 4'd8;
            skip_reg      <= 1'b0;
            dp_reg        <= '0;
            cvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dp_reg        <= dp_next;
            cvalid_reg    <= cvalid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CLUSTERS: act_cl_reg  <= cfg_data;
                    REG_DIMS:     act_dim_reg <= cfg_data[3:0];
                    REG_SKIP:     skip_reg    <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        d_reg        <= d_next;
        pid_reg      <= pid_next;
        lastpt_reg   <= lastpt_next;
        newcnt_reg   <= newcnt_next;
        dcnt_reg     <= dcnt_next;
        emit_reg     <= emit_next;
        out_data_reg <= out_data_next;
    end

endmodule

[hw/rtl/kau_div.sv]
module kau_div
    import kau_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0]        divisor,
    output logic                    done,
    output logic signed [VAL_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [CNT_W:0]    rem_sh;
    logic [SUM_W-1:0]  qneg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[CNT_W-1:0], dvd_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[SUM_W-1];
            dvd_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift one quotient bit into the dividend register per cycle
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    assign qneg     = neg_reg ? (~dvd_reg + SUM_W'(1)) : dvd_reg;
    assign done     = done_reg;
    assign quotient = qneg[VAL_W-1:0];

endmodule

[hw/rtl/kau_dist.sv]
module kau_dist
    import kau_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cload_t          cload,
    input  dist_req_t       req,
    input  logic [NC_W-1:0] nclusters,
    input  logic            skip_equal,
    output dist_res_t       res
);

    logic signed [VAL_W-1:0] cmem [MAX_CLUSTERS*MAX_DIMS];
    pent_t                   pmem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] pvalid_reg;

    logic                    issue_reg;
    logic [CL_W-1:0]         ic_reg;
    logic [DIM_W-1:0]        elem_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    last_reg;

    logic signed [VAL_W-1:0] c_q;
    pent_t                   p_q;

    logic            s1_v_reg, s1_end_reg;
    logic [CL_W-1:0] s1_c_reg;
    logic            s2_v_reg, s2_end_reg;
    logic [CL_W-1:0] s2_c_reg;
    logic [31:0]     sq_reg;
    logic [DIST_W-1:0] old_reg;
    logic            eqo_reg, eqz_reg;
    logic            s3_v_reg, s3_end_reg;
    logic [CL_W-1:0] s3_c_reg;
    logic [DIST_W-1:0] s3_dist_reg;
    logic            s3_eq_reg;

    logic              found_reg;
    logic [CL_W-1:0]   best_reg;
    logic [DIST_W-1:0] bestd_reg;
    logic              done_reg;

    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] prod;
    logic [DIST_W-1:0]         new_dist;
    logic                      elig;
    logic                      at_end;

    assign diff     = {value_reg[VAL_W-1], value_reg} - {c_q[VAL_W-1], c_q};
    assign prod     = diff * diff;
    assign new_dist = old_reg + DIST_W'(sq_reg);
    assign elig     = !(skip_equal && s3_eq_reg);
    assign at_end   = ({1'b0, ic_reg} == nclusters - NC_W'(1));

    always_ff @(posedge clk)
    begin
        if (cload.en)
            cmem[{cload.sel, cload.elem}] <= cload.value;
        c_q <= cmem[{ic_reg, elem_reg}];
        p_q <= pmem[ic_reg];
        if (s2_v_reg)
            pmem[s2_c_reg] <= '{eq: eqo_reg && eqz_reg, acc: new_dist};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            s3_v_reg   <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            pvalid_reg <= '0;
        end
        else
        begin
            s1_v_reg <= issue_reg;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            done_reg <= s3_v_reg && s3_end_reg;
            if (req.start)
            begin
                issue_reg <= 1'b1;
                found_reg <= 1'b0;
            end
            else if (issue_reg && at_end)
                issue_reg <= 1'b0;
            if (s3_v_reg && last_reg && elig && (!found_reg || s3_dist_reg < bestd_reg))
                found_reg <= 1'b1;
            // a finished point returns all partial sums to their reset value
            if (s3_v_reg && s3_end_reg && last_reg)
                pvalid_reg <= '0;
            else if (s2_v_reg)
                pvalid_reg[s2_c_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ic_reg    <= '0;
            elem_reg  <= req.elem;
            value_reg <= req.value;
            last_reg  <= req.last;
        end
        else if (issue_reg)
            ic_reg <= ic_reg + CL_W'(1);
        s1_c_reg    <= ic_reg;
        s1_end_reg  <= at_end;
        s2_c_reg    <= s1_c_reg;
        s2_end_reg  <= s1_end_reg;
        sq_reg      <= prod[31:0];
        eqz_reg     <= (diff == '0);
        old_reg     <= pvalid_reg[s1_c_reg] ? p_q.acc : '0;
        eqo_reg     <= pvalid_reg[s1_c_reg] ? p_q.eq : 1'b1;
        s3_c_reg    <= s2_c_reg;
        s3_end_reg  <= s2_end_reg;
        s3_dist_reg <= new_dist;
        s3_eq_reg   <= eqo_reg && eqz_reg;
        if (s3_v_reg && last_reg && elig && (!found_reg || s3_dist_reg < bestd_reg))
        begin
            best_reg  <= s3_c_reg;
            bestd_reg <= s3_dist_reg;
        end
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign res.best  = best_reg;

endmodule

[hw/rtl/kau_check.sv]
module kau_check
    import kau_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input req_t              in_data,
    input logic              out_valid,
    input logic              out_ready,
    input res_t              out_data,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [CFG_IW-1:0] cfg_index,
    input logic [CFG_DW-1:0] cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_ASSIGN && !out_data.found
        |-> out_data.member_count == '0 && out_data.cluster_out == '0)
        else $error("unassigned point carries a cluster");

    a_mean_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_MEAN |-> out_data.member_count != '0)
        else $error("mean emitted for an empty cluster");

    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_DONE
        |-> !out_data.last && out_data.member_count == '0)
        else $error("drain end marker carries data");

endmodule

bind kmeans_assign_update_core kau_check u_check (.*);

[dv/kmeans_assign_update_core_test.sv]
module kmeans_assign_update_core_test;
    import kau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    res_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    kmeans_assign_update_core DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow copy of the block state
    logic [4:0] n_clusters_reg;
    logic [3:0] n_dims_reg;
    logic skip_reg;
    logic signed [15:0] centroid_mem [MAX_CLUSTERS][MAX_DIMS];
    logic signed [15:0] point_elems [MAX_DIMS];
    logic [63:0] dist_acc [MAX_CLUSTERS];
    bit match_acc [MAX_CLUSTERS];
    longint sum_mem [MAX_CLUSTERS][MAX_DIMS];
    int count_mem [MAX_CLUSTERS];
    int next_drain;

    req_t request_queue [$];
    res_t expected_results [$];
    int queued_total = 0;
    int mismatch_count = 0;
    int unexpected_count = 0;
    int result_count = 0;
    int assign_count = 0;
    int mean_count = 0;
    longint cycle_count = 0;
    bit stim_done = 0;

    function automatic int clusters_in_use();
        return n_clusters_reg == 0 ? 1 : (n_clusters_reg > MAX_CLUSTERS ? MAX_CLUSTERS
            : int'(n_clusters_reg));
    endfunction

    function automatic int dims_in_use();
        return n_dims_reg == 0 ? 1 : (n_dims_reg > MAX_DIMS ? MAX_DIMS : int'(n_dims_reg));
    endfunction

    function automatic void reset_partials();
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            dist_acc[c] = '0;
            match_acc[c] = 1'b1;
        end
    endfunction

    function automatic void clear_clusters();
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            count_mem[c] = 0;
            for (int d = 0; d < MAX_DIMS; d++)
                sum_mem[c][d] = 0;
        end
        next_drain = 0;
    endfunction

    function automatic void expect_result(res_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void queue_req(req_t q);
        request_queue.insert(request_queue.size(), q);
        queued_total++;
    endfunction

    function automatic void predict_kmeans(req_t rq);
        int nc;
        int nd;
        int best;
        bit fnd;
        longint df;
        logic [63:0] bestd;
        res_t r;
        nc = clusters_in_use();
        nd = dims_in_use();
        r = '0;
        best = 0;
        fnd = 0;
        bestd = '0;
        case (rq.op)
            OP_LOAD: centroid_mem[rq.cluster_sel][rq.elem_index] = rq.elem_value;
            OP_POINT:
            begin
                if (rq.elem_index < nd)
                begin
                    point_elems[rq.elem_index] = rq.elem_value;
                    for (int c = 0; c < nc; c++)
                    begin
                        df = longint'(rq.elem_value) - longint'(centroid_mem[c][rq.elem_index]);
                        dist_acc[c] += 64'(df * df);
                        if (df != 0)
                            match_acc[c] = 1'b0;
                    end
                    if (rq.elem_index == nd - 1)
                    begin
                        for (int c = 0; c < nc; c++)
                        begin
                            if (skip_reg && match_acc[c])
                                continue;
                            if (!fnd || dist_acc[c] < bestd)
                            begin
                                fnd = 1;
                                best = c;
                                bestd = dist_acc[c];
                            end
                        end
                        reset_partials();
                        r.kind = KIND_ASSIGN;
                        r.assigned_point = rq.point_id;
                        if (fnd)
                        begin
                            if (count_mem[best] < MAX_POINTS)
                            begin
                                for (int d = 0; d < nd; d++)
                                    sum_mem[best][d] += point_elems[d];
                                count_mem[best]++;
                            end
                            r.found = 1'b1;
                            r.cluster_out = best[3:0];
                            r.member_count = count_mem[best][CNT_W-1:0];
                        end
                        expect_result(r);
                    end
                end
            end
            OP_DRAIN:
            begin
                for (int c = next_drain; c < nc; c++)
                begin
                    if (count_mem[c] != 0)
                    begin
                        for (int d = 0; d < nd; d++)
                        begin
                            r = '0;
                            r.kind = KIND_MEAN;
                            r.cluster_out = c[3:0];
                            r.member_count = count_mem[c][CNT_W-1:0];
                            r.mean_index = d[2:0];
                            r.mean_value = 16'(sum_mem[c][d] / longint'(count_mem[c]));
                            r.last = (d == nd - 1);
                            expect_result(r);
                        end
                        next_drain = c + 1;
                        return;
                    end
                end
                next_drain = 0;
                r.kind = KIND_DONE;
                expect_result(r);
            end
            default: clear_clusters();
        endcase
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_kmeans(in_data);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= request_queue.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            stall_phase <= (stall_phase + 1) % 64;
            out_ready <= (stall_phase < 24) ? 1'b1
                : (stall_phase < 48 ? ($urandom_range(0, 2) != 0) : 1'b0);
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (out_data.kind == KIND_ASSIGN)
                    assign_count <= assign_count + 1;
                if (out_data.kind == KIND_MEAN)
                    mean_count <= mean_count + 1;
                if (expected_results.size() == 0)
                begin
                    unexpected_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r !== out_data)
                    begin
                        mismatch_count++;
                        if (mismatch_count + unexpected_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, out_data);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CLUSTERS: n_clusters_reg = val;
            REG_DIMS: n_dims_reg = val[3:0];
            default: skip_reg = val[0];
        endcase
    endtask

    task automatic wait_idle();
        while (request_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [1:0] op, int sel, int ei, int val, int pid);
        req_t q;
        q.op = op;
        q.cluster_sel = sel[3:0];
        q.elem_index = ei[2:0];
        q.elem_value = val[15:0];
        q.point_id = pid[15:0];
        return q;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return -32768;
            2: return $urandom_range(0, 65535);
            default: return int'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    // reload the active centroids, then points and drains, then a final clear
    function automatic void queue_phase(int n_points, int nc, int nd);
        int v;
        int cvals [MAX_CLUSTERS][MAX_DIMS];
        for (int c = 0; c < nc; c++)
            for (int d = 0; d < nd; d++)
            begin
                cvals[c][d] = rand_value();
                queue_req(make_req(OP_LOAD, c, d, cvals[c][d], 0));
            end
        for (int p = 0; p < n_points; p++)
        begin
            int copy_c;
            copy_c = $urandom_range(0, 3) == 0 ? $urandom_range(0, nc - 1) : -1;
            for (int d = 0; d < nd; d++)
            begin
                v = rand_value();
                if (copy_c >= 0)
                    v = cvals[copy_c][d];
                queue_req(make_req(OP_POINT, $urandom_range(0, 15), d, v,
                    $urandom_range(0, 65535)));
            end
            if (nd < MAX_DIMS && $urandom_range(0, 9) == 0)
                queue_req(make_req(OP_POINT, 0, $urandom_range(nd, 7), 5, 0));
            if ($urandom_range(0, 5) == 0)
                queue_req(make_req(OP_DRAIN, $urandom_range(0, 15), 0, 0, 0));
        end
        for (int k = 0; k <= nc; k++)
            queue_req(make_req(OP_DRAIN, 0, 0, 0, 0));
        queue_req(make_req(OP_CLEAR, 0, 0, 0, 0));
    endfunction

    initial
    begin
        n_clusters_reg = 5'd16;
        n_dims_reg = 4'd8;
        skip_reg = 1'b0;
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int d = 0; d < MAX_DIMS; d++)
                centroid_mem[c][d] = '0;
        for (int d = 0; d < MAX_DIMS; d++)
            point_elems[d] = '0;
        reset_partials();
        clear_clusters();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: two dims, two clusters, ties, equal skip, extremes
        write_reg(REG_CLUSTERS, 5'd2);
        write_reg(REG_DIMS, 4'd2);
        write_reg(REG_SKIP, 5'd1);
        for (int c = 0; c < MAX_CLUSTERS; c++)
            for (int d = 0; d < MAX_DIMS; d++)
                queue_req(make_req(OP_LOAD, c, d, (c == 1) ? 32767 : 0, 0));
        queue_req(make_req(OP_POINT, 0, 0, 0, 1));
        queue_req(make_req(OP_POINT, 0, 1, 0, 2));
        queue_req(make_req(OP_POINT, 0, 5, 7, 0));
        queue_req(make_req(OP_POINT, 0, 0, -32768, 65535));
        queue_req(make_req(OP_POINT, 0, 1, 32767, 65535));
        queue_req(make_req(OP_DRAIN, 0, 0, 0, 0));
        queue_req(make_req(OP_DRAIN, 0, 0, 0, 0));
        queue_req(make_req(OP_DRAIN, 0, 0, 0, 0));
        queue_req(make_req(OP_CLEAR, 0, 0, 0, 0));
        queue_req(make_req(OP_DRAIN, 0, 0, 0, 0));
        wait_idle();
        write_reg(REG_SKIP, 5'd0);
        queue_req(make_req(OP_POINT, 0, 0, 16383, 3));
        queue_req(make_req(OP_POINT, 0, 1, 16384, 4));
        queue_req(make_req(OP_POINT, 0, 0, 0, 5));
        queue_req(make_req(OP_POINT, 0, 1, 0, 6));
        wait_idle();

        while (queued_total < 400)
        begin
            int nc;
            int nd;
            case ($urandom_range(0, 4))
                0: nc = 16;
                1: nc = 1;
                default: nc = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 4))
                0: nd = 8;
                1: nd = 1;
                default: nd = $urandom_range(1, 8);
            endcase
            write_reg(REG_CLUSTERS, ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                : 5'(nc));
            write_reg(REG_DIMS, ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                : 4'(nd));
            write_reg(REG_SKIP, 5'($urandom_range(0, 1)));
            queue_phase($urandom_range(6, 20), clusters_in_use(), dims_in_use());
            wait_idle();
        end
        write_reg(REG_CLUSTERS, 5'd0);
        write_reg(REG_DIMS, 4'd0);
        queue_phase(4, 1, 1);
        wait_idle();
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done || cycle_count > 2000000);
        if (!stim_done)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            $display("Covered %0d requests and %0d results: %0d assignments, %0d mean elements.",
                queued_total, result_count, assign_count, mean_count);
            if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end
endmodule

[filelist.f]
hw/rtl/kau_pkg.sv
hw/rtl/kau_div.sv
hw/rtl/kau_dist.sv
hw/rtl/kmeans_assign_update_core.sv
hw/rtl/kau_check.sv
dv/kmeans_assign_update_core_test.sv
